[rtl/bsmd_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// bsmd_pkg
// Shared constants, types and the control store of the dihedral binary
// shape matcher.
// ----------------------------------------------------------------------------
package bsmd_pkg;

  localparam int unsigned MaxSide    = 128;
  localparam int unsigned StoreDepth = MaxSide * MaxSide;
  localparam int unsigned AddrW      = $clog2(StoreDepth);
  localparam int unsigned CoordW     = $clog2(MaxSide);
  localparam int unsigned SideW      = 8;
  localparam int unsigned PixW       = 8;
  localparam int unsigned CntW       = 15;
  localparam int unsigned CfgIdxW    = 1;
  localparam int unsigned CfgDataW   = 15;

  localparam logic [PixW-1:0] BgCode    = 8'd255;
  localparam logic [PixW-1:0] FgCode    = 8'd0;
  localparam logic [PixW-1:0] BinThresh = 8'd127;

  localparam logic [SideW-1:0] SideMin   = 8'd2;
  localparam logic [SideW-1:0] SideMax   = 8'(MaxSide);
  localparam logic [SideW-1:0] SideReset = 8'd93;
  localparam logic [CntW-1:0]  MinMatchReset = 15'd8347;

  localparam logic [CfgIdxW-1:0] CFG_IMAGE_SIDE  = 1'd0;
  localparam logic [CfgIdxW-1:0] CFG_MIN_MATCHES = 1'd1;

  localparam int unsigned StepW = 3;
  localparam logic [StepW-1:0] STEP_LOAD  = 3'd0;
  localparam logic [StepW-1:0] STEP_INIT  = 3'd1;
  localparam logic [StepW-1:0] STEP_SCAN  = 3'd2;
  localparam logic [StepW-1:0] STEP_DRAIN = 3'd3;
  localparam logic [StepW-1:0] STEP_EMIT  = 3'd4;

  typedef enum logic [2:0] {
    COND_ALWAYS,
    COND_FRAME_END,
    COND_SCAN_END,
    COND_DRAINED,
    COND_OUT_FREE
  } cond_e;

  typedef struct packed {
    logic             accept;
    logic             clr_scan;
    logic             scan_en;
    logic             emit;
    cond_e            cond;
    logic [StepW-1:0] target;
  } ucode_t;

  typedef struct packed {
    logic accept;
    logic clr_scan;
    logic scan_en;
    logic emit;
  } seq_ctrl_t;

  typedef struct packed {
    logic frame_end;
    logic scan_end;
    logic drained;
    logic out_free;
  } seq_status_t;

  typedef struct packed {
    logic             first;
    logic             last;
    logic [AddrW-1:0] ref_addr;
    logic [AddrW-1:0] cand_addr;
  } scan_beat_t;

  // Control store: each step holds until its condition is true, then jumps.
  function automatic ucode_t ucode_rom(input logic [StepW-1:0] step);
    ucode_t w;
    w = '{accept: 1'b0, clr_scan: 1'b0, scan_en: 1'b0, emit: 1'b0,
          cond: COND_ALWAYS, target: STEP_LOAD};
    case (step)
      STEP_LOAD: begin
        w.accept = 1'b1;
        w.cond   = COND_FRAME_END;
        w.target = STEP_INIT;
      end
      STEP_INIT: begin
        w.clr_scan = 1'b1;
        w.cond     = COND_ALWAYS;
        w.target   = STEP_SCAN;
      end
      STEP_SCAN: begin
        w.scan_en = 1'b1;
        w.cond    = COND_SCAN_END;
        w.target  = STEP_DRAIN;
      end
      STEP_DRAIN: begin
        w.cond   = COND_DRAINED;
        w.target = STEP_EMIT;
      end
      STEP_EMIT: begin
        w.emit   = 1'b1;
        w.cond   = COND_OUT_FREE;
        w.target = STEP_LOAD;
      end
      default: begin
        w.cond   = COND_ALWAYS;
        w.target = STEP_LOAD;
      end
    endcase
    return w;
  endfunction

endpackage
`default_nettype wire

[rtl/binary_shape_match_dihedral_core.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// binary_shape_match_dihedral_core
// Rotation and mirror invariant binary template match over square images.
//
// Input channel (in_valid_i / in_stall_o): one beat per pixel pair in raster
// order, ref_pixel_i raw, cand_pixel_i binarized (above 127 = background).
// A frame of side*side beats loads at one beat per cycle. After the last beat
// input stalls while the compare runs: a setup step, the scan of all eight
// orientations (one position per cycle through the single read port of each
// pixel store), a drain of the compare pipeline, then one result beat is
// loaded into the output register.
// Output channel (out_valid_o / out_stall_i): is_match_o, best_count_o. The
// result holds while stalled; the next frame loads meanwhile, and a finished
// compare waits in its last step until the output register is free.
// Configuration (cfg_valid_i / cfg_ready_o, always ready): index 0 image side,
// clamped to 2..128; index 1 match threshold. Write only between frames.
// Reset: loader at pixel 0, side 93, threshold 8347; pixel stores not cleared.
// ----------------------------------------------------------------------------
module binary_shape_match_dihedral_core (
  input  wire                             clk_i,
  input  wire                             rst_ni,
  input  wire                             in_valid_i,
  output logic                            in_stall_o,
  input  wire  [bsmd_pkg::PixW-1:0]       ref_pixel_i,
  input  wire  [bsmd_pkg::PixW-1:0]       cand_pixel_i,
  output logic                            out_valid_o,
  input  wire                             out_stall_i,
  output logic                            is_match_o,
  output logic [bsmd_pkg::CntW-1:0]       best_count_o,
  input  wire                             cfg_valid_i,
  output logic                            cfg_ready_o,
  input  wire  [bsmd_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  wire  [bsmd_pkg::CfgDataW-1:0]   cfg_wdata_i
);
  import bsmd_pkg::*;

  // configuration
  logic [CoordW-1:0] nm1_q;
  logic [CntW-1:0]   nn_q;
  logic [CntW-1:0]   min_q;
  logic [SideW-1:0]  side_eff;
  logic              cfg_we;

  always_comb begin
    side_eff = cfg_wdata_i[SideW-1:0];
    if (side_eff < SideMin) side_eff = SideMin;
    if (side_eff > SideMax) side_eff = SideMax;
  end

  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nm1_q <= CoordW'(SideReset - 8'd1);
      nn_q  <= CntW'(SideReset) * CntW'(SideReset);
      min_q <= MinMatchReset;
    end else if (cfg_we) begin
      if (cfg_index_i == CFG_IMAGE_SIDE) begin
        nm1_q <= CoordW'(side_eff - 8'd1);
        nn_q  <= CntW'(side_eff) * CntW'(side_eff);
      end else if (cfg_index_i == CFG_MIN_MATCHES) begin
        min_q <= cfg_wdata_i[CntW-1:0];
      end
    end
  end

  // sequencer
  seq_ctrl_t        ctrl;
  seq_status_t      status;
  logic [StepW-1:0] step;

  bsmd_seq u_seq (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .status_i (status),
    .ctrl_o   (ctrl),
    .step_o   (step)
  );

  // loader
  logic             in_acc;
  logic [CntW-1:0]  li_q;
  logic [CntW-1:0]  li_next;
  logic             frame_last;
  logic             store_we;

  assign in_stall_o = !ctrl.accept;
  assign in_acc     = in_valid_i && !in_stall_o;
  assign li_next    = li_q + 1'b1;
  assign frame_last = ({1'b0, li_next} >= {1'b0, nn_q});
  assign store_we   = in_acc && !li_q[AddrW];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      li_q <= '0;
    end else if (in_acc) begin
      li_q <= frame_last ? '0 : li_next;
    end
  end

  // scan address generator
  logic       scan_done;
  logic       s1_vld;
  scan_beat_t s1;

  bsmd_scan u_scan (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .clr_i      (ctrl.clr_scan),
    .adv_i      (ctrl.scan_en),
    .nm1_i      (nm1_q),
    .done_o     (scan_done),
    .beat_vld_o (s1_vld),
    .beat_o     (s1)
  );

  // pixel stores
  logic [PixW-1:0] ref_mem [StoreDepth];
  logic            cand_mem [StoreDepth];
  logic [PixW-1:0] ref_rd_q;
  logic            cand_rd_q;

  always_ff @(posedge clk_i) begin
    if (store_we) begin
      ref_mem[li_q[AddrW-1:0]] <= ref_pixel_i;
    end
    ref_rd_q <= ref_mem[s1.ref_addr];
  end

  always_ff @(posedge clk_i) begin
    if (store_we) begin
      cand_mem[li_q[AddrW-1:0]] <= (cand_pixel_i > BinThresh);
    end
    cand_rd_q <= cand_mem[s1.cand_addr];
  end

  // compare and accumulate
  logic            s2_vld_q, s2_first_q, s2_last_q;
  logic [PixW-1:0] code;
  logic            eq;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [CntW-1:0] best_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_vld_q <= 1'b0;
    end else begin
      s2_vld_q <= s1_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    s2_first_q <= s1.first;
    s2_last_q  <= s1.last;
  end

  assign code  = cand_rd_q ? BgCode : FgCode;
  assign eq    = (ref_rd_q == code);
  assign cnt_d = (s2_first_q ? '0 : cnt_q) + CntW'(eq);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      best_q <= '0;
    end else begin
      if (ctrl.clr_scan) begin
        best_q <= '0;
      end else if (s2_vld_q) begin
        cnt_q <= cnt_d;
        if (s2_last_q && (cnt_d > best_q)) begin
          best_q <= cnt_d;
        end
      end
    end
  end

  // result register
  logic            out_vld_q;
  logic            match_q;
  logic [CntW-1:0] out_cnt_q;

  assign status.frame_end = in_acc && frame_last;
  assign status.scan_end  = scan_done;
  assign status.drained   = !s1_vld && !s2_vld_q;
  assign status.out_free  = !out_vld_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (ctrl.emit) begin
      out_vld_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl.emit) begin
      match_q   <= (best_q >= min_q);
      out_cnt_q <= best_q;
    end
  end

  assign out_valid_o  = out_vld_q;
  assign is_match_o   = match_q;
  assign best_count_o = out_cnt_q;

`ifndef NO_ASSERTIONS
  a_no_load_while_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_vld || s2_vld_q) |-> in_stall_o)
    else $error("input accepted while compare pipeline busy");

  a_emit_after_drain : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.emit |-> (!s1_vld && !s2_vld_q))
    else $error("result emitted before compare drained");

  a_result_from_emit : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_vld_q) |-> $past(step == STEP_EMIT))
    else $error("result beat not issued by emit step");

  a_no_overwrite : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && out_stall_i) |-> !ctrl.emit)
    else $error("stalled result overwritten");
`endif

endmodule
`default_nettype wire

[rtl/bsmd_seq.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// bsmd_seq
// Step counter and control store; one control word per step, conditional jump.
// ----------------------------------------------------------------------------
module bsmd_seq (
  input  wire                    clk_i,
  input  wire                    rst_ni,
  input  wire bsmd_pkg::seq_status_t status_i,
  output bsmd_pkg::seq_ctrl_t    ctrl_o,
  output logic [bsmd_pkg::StepW-1:0] step_o
);
  import bsmd_pkg::*;

  logic [StepW-1:0] step_q, step_d;
  ucode_t           word;
  logic             cond_true;

  assign word = ucode_rom(step_q);

  always_comb begin
    case (word.cond)
      COND_ALWAYS:    cond_true = 1'b1;
      COND_FRAME_END: cond_true = status_i.frame_end;
      COND_SCAN_END:  cond_true = status_i.scan_end;
      COND_DRAINED:   cond_true = status_i.drained;
      COND_OUT_FREE:  cond_true = status_i.out_free;
      default:        cond_true = 1'b0;
    endcase
  end

  assign step_d = cond_true ? word.target : step_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= STEP_LOAD;
    end else begin
      step_q <= step_d;
    end
  end

  assign ctrl_o.accept   = word.accept;
  assign ctrl_o.clr_scan = word.clr_scan;
  assign ctrl_o.scan_en  = word.scan_en;
  assign ctrl_o.emit     = word.emit & cond_true;
  assign step_o          = step_q;

endmodule
`default_nettype wire

[rtl/bsmd_scan.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// bsmd_scan
// Walks orientation, row and column; forms reference and rotated or mirrored
// candidate addresses, one position per cycle while advancing, registered.
// ----------------------------------------------------------------------------
module bsmd_scan (
  input  wire                           clk_i,
  input  wire                           rst_ni,
  input  wire                           clr_i,
  input  wire                           adv_i,
  input  wire [bsmd_pkg::CoordW-1:0]    nm1_i,
  output logic                          done_o,
  output logic                          beat_vld_o,
  output bsmd_pkg::scan_beat_t          beat_o
);
  import bsmd_pkg::*;

  logic [2:0]        t_q;
  logic [CoordW-1:0] r_q, c_q;
  logic [AddrW-1:0]  ra_q;
  logic              row_end, orient_end;
  logic [CoordW-1:0] cm, sr, sc;
  logic [SideW-1:0]  side;
  logic [AddrW-1:0]  idx;
  logic              vld_q;
  scan_beat_t        beat_q;

  assign row_end    = (c_q == nm1_i);
  assign orient_end = row_end && (r_q == nm1_i);
  assign done_o     = adv_i && orient_end && (t_q == 3'd7);

  always_comb begin
    cm = t_q[2] ? (nm1_i - c_q) : c_q;
    case (t_q[1:0])
      2'd0: begin sr = r_q;          sc = cm;          end
      2'd1: begin sr = cm;           sc = nm1_i - r_q; end
      2'd2: begin sr = nm1_i - r_q;  sc = nm1_i - cm;  end
      default: begin sr = nm1_i - cm; sc = r_q;        end
    endcase
  end

  assign side = {1'b0, nm1_i} + 8'd1;
  assign idx  = AddrW'(sr) * AddrW'(side) + AddrW'(sc);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      t_q   <= '0;
      r_q   <= '0;
      c_q   <= '0;
      ra_q  <= '0;
      vld_q <= 1'b0;
    end else begin
      vld_q <= adv_i;
      if (clr_i) begin
        t_q  <= '0;
        r_q  <= '0;
        c_q  <= '0;
        ra_q <= '0;
      end else if (adv_i) begin
        if (orient_end) begin
          c_q  <= '0;
          r_q  <= '0;
          ra_q <= '0;
          t_q  <= t_q + 3'd1;
        end else if (row_end) begin
          c_q  <= '0;
          r_q  <= r_q + 1'b1;
          ra_q <= ra_q + 1'b1;
        end else begin
          c_q  <= c_q + 1'b1;
          ra_q <= ra_q + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      beat_q.first     <= (r_q == '0) && (c_q == '0);
      beat_q.last      <= orient_end;
      beat_q.ref_addr  <= ra_q;
      beat_q.cand_addr <= idx;
    end
  end

  assign beat_vld_o = vld_q;
  assign beat_o     = beat_q;

endmodule
`default_nettype wire

[verif/binary_shape_match_dihedral_core_tb.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// binary_shape_match_dihedral_core_tb
// Self-checking bench for the dihedral binary shape matcher. Frames of pixel
// pairs are pushed through the input channel. A scoreboard keeps its own copy
// of both pixel stores and the registers, scores all eight orientations
// when a frame completes, and compares every output beat field by field.
// It starts with a load at reset settings that a side cut ends, then short
// directed frames (clamped sides, threshold extremes, a side cut during a
// load), then randomized frames under varying backpressure, and a load at
// the clamped top side that a side cut ends.
// ----------------------------------------------------------------------------
module binary_shape_match_dihedral_core_tb;
  import bsmd_pkg::*;

  typedef enum int unsigned {
    FRAME_RAW,
    FRAME_BINARY,
    FRAME_ORIENTED
  } frame_kind_e;

  class match_scoreboard;
    typedef struct packed {
      logic            is_match;
      logic [CntW-1:0] best_count;
    } verdict_t;

    logic [SideW-1:0] side_reg;
    logic [CntW-1:0]  min_reg;
    logic [PixW-1:0]  ref_mem [StoreDepth];
    bit               cand_bg [StoreDepth];
    logic [CntW-1:0]  load_idx;
    verdict_t         verdicts[$];
    int               errors;

    function new();
      side_reg    = SideReset;
      min_reg     = MinMatchReset;
      load_idx    = '0;
      errors      = 0;
    endfunction

    static function int unsigned src_index(int unsigned n, int unsigned t,
                                           int unsigned r, int unsigned c);
      int unsigned cm, sr, sc;
      cm = (t & 4) ? (n - 1 - c) : c;
      case (t % 4)
        0: begin
          sr = r;
          sc = cm;
        end
        1: begin
          sr = cm;
          sc = n - 1 - r;
        end
        2: begin
          sr = n - 1 - r;
          sc = n - 1 - cm;
        end
        default: begin
          sr = n - 1 - cm;
          sc = r;
        end
      endcase
      return (sr * n + sc) % StoreDepth;
    endfunction

    function int unsigned frame_side();
      if (side_reg < SideMin) return SideMin;
      if (side_reg > SideMax) return SideMax;
      return side_reg;
    endfunction

    function bit loading();
      return load_idx != '0;
    endfunction

    function int pending();
      return verdicts.size();
    endfunction

    task report(string msg);
      $display("MISMATCH: %s", msg);
      errors++;
    endtask

    function void write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] d);
      if (idx == CFG_IMAGE_SIDE) side_reg = d[SideW-1:0];
      else if (idx == CFG_MIN_MATCHES) min_reg = d[CntW-1:0];
    endfunction

    function int unsigned orient_hits(int unsigned n, int unsigned t);
      int unsigned hits;
      logic [PixW-1:0] code;
      hits = 0;
      for (int unsigned r = 0; r < n; r++) begin
        for (int unsigned c = 0; c < n; c++) begin
          code = cand_bg[src_index(n, t, r, c)] ? BgCode : FgCode;
          if (ref_mem[(r * n + c) % StoreDepth] == code) hits++;
        end
      end
      return hits;
    endfunction

    function void note_pixel(logic [PixW-1:0] rp, logic [PixW-1:0] cp);
      int unsigned n, best, hits;
      verdict_t v;
      n = frame_side();
      if (load_idx < StoreDepth) begin
        ref_mem[load_idx] = rp;
        cand_bg[load_idx] = (cp > BinThresh);
      end
      load_idx = load_idx + 1'b1;
      if (load_idx < n * n) return;
      load_idx = '0;
      best = 0;
      for (int unsigned t = 0; t < 8; t++) begin
        hits = orient_hits(n, t);
        if (hits > best) best = hits;
      end
      v.best_count = best[CntW-1:0];
      v.is_match   = (v.best_count >= min_reg);
      verdicts.push_back(v);
    endfunction

    task check_result(logic m, logic [CntW-1:0] b);
      verdict_t v;
      if (verdicts.size() == 0) begin
        report($sformatf("result beat with no frame pending: match %0b count %0d", m, b));
        return;
      end
      v = verdicts.pop_front();
      if (m !== v.is_match)
        report($sformatf("is_match %0b, want %0b", m, v.is_match));
      if (b !== v.best_count)
        report($sformatf("best_count %0d, want %0d", b, v.best_count));
    endtask
  endclass

  logic                clk = 1'b0;
  logic                rst_ni;
  logic                in_valid;
  logic                in_stall_o;
  logic [PixW-1:0]     ref_pixel;
  logic [PixW-1:0]     cand_pixel;
  logic                out_valid_o;
  logic                out_stall = 1'b0;
  logic                is_match_o;
  logic [CntW-1:0]     best_count_o;
  logic                cfg_valid;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index;
  logic [CfgDataW-1:0] cfg_wdata;

  match_scoreboard sb = new();

  int unsigned tx_idle = 28;
  int unsigned rx_idle = 62;
  int          hold_left = 0;
  int unsigned pixel_count = 0;
  logic [PixW-1:0] frame_ref  [StoreDepth];
  logic [PixW-1:0] frame_cand [StoreDepth];

  binary_shape_match_dihedral_core dut (
    .clk_i        (clk),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid),
    .in_stall_o   (in_stall_o),
    .ref_pixel_i  (ref_pixel),
    .cand_pixel_i (cand_pixel),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall),
    .is_match_o   (is_match_o),
    .best_count_o (best_count_o),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index),
    .cfg_wdata_i  (cfg_wdata)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else begin
      out_stall <= ($urandom_range(99) < rx_idle);
    end
  end

  always @(posedge clk) begin
    if (rst_ni && out_valid_o && !out_stall) sb.check_result(is_match_o, best_count_o);
  end

  task automatic send_pixel(logic [PixW-1:0] rp, logic [PixW-1:0] cp);
    while ($urandom_range(99) < tx_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    ref_pixel  <= rp;
    cand_pixel <= cp;
    @(posedge clk);
    while (in_stall_o) @(posedge clk);
    sb.note_pixel(rp, cp);
    pixel_count++;
  endtask

  task automatic send_frame(int unsigned count);
    for (int unsigned i = 0; i < count; i++) send_pixel(frame_ref[i], frame_cand[i]);
  endtask

  // quiet input, let all pending results out, then a short settle
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
  endtask

  task automatic cfg_write(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] d);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= d;
    @(posedge clk);
    while (!cfg_ready_o) @(posedge clk);
    sb.write_reg(idx, d);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic build_frame(int unsigned n, frame_kind_e kind, int unsigned noise);
    int unsigned t, i;
    bit bg;
    t = $urandom_range(7);
    for (int unsigned r = 0; r < n; r++) begin
      for (int unsigned c = 0; c < n; c++) begin
        i = r * n + c;
        case (kind)
          FRAME_RAW: begin
            frame_ref[i]  = 8'($urandom_range(255));
            frame_cand[i] = 8'($urandom_range(255));
          end
          FRAME_BINARY: begin
            if ($urandom_range(9) == 0) frame_ref[i] = 8'($urandom_range(255));
            else frame_ref[i] = $urandom_range(1) ? BgCode : FgCode;
            frame_cand[i] = 8'($urandom_range(255));
          end
          default: frame_ref[i] = $urandom_range(1) ? BgCode : FgCode;
        endcase
      end
    end
    if (kind == FRAME_ORIENTED) begin
      // candidate is one orientation of the reference, with some bits flipped
      for (int unsigned r = 0; r < n; r++) begin
        for (int unsigned c = 0; c < n; c++) begin
          bg = (frame_ref[r * n + c] == BgCode) ^ ($urandom_range(99) < noise);
          i = match_scoreboard::src_index(n, t, r, c);
          frame_cand[i] = bg ? 8'($urandom_range(255, 128)) : 8'($urandom_range(127, 0));
        end
      end
    end
  endtask

  initial begin
    int unsigned n, k, sidev, rand_start, group, rel;
    logic [CfgDataW-1:0] d;
    frame_kind_e kind;

    rst_ni     = 1'b0;
    in_valid   = 1'b0;
    ref_pixel  = '0;
    cand_pixel = '0;
    cfg_valid  = 1'b0;
    cfg_index  = '0;
    cfg_wdata  = '0;
    repeat (9) @(posedge clk);
    rst_ni <= 1'b1;
    @(posedge clk);

    // reset side keeps loading past twelve beats; a cut to 3 ends the frame
    build_frame(4, FRAME_ORIENTED, 0);
    send_frame(12);
    wait_drained();
    cfg_write(CFG_IMAGE_SIDE, 15'd3);
    send_pixel(frame_ref[12], frame_cand[12]);
    wait_drained();

    // side 0 clamps to 2, zero threshold always matches
    cfg_write(CFG_IMAGE_SIDE, '0);
    cfg_write(CFG_MIN_MATCHES, '0);
    frame_ref[0]  = FgCode; frame_ref[1]  = BgCode; frame_ref[2]  = FgCode;
    frame_ref[3]  = BgCode;
    frame_cand[0] = 8'd0;   frame_cand[1] = 8'd255; frame_cand[2] = 8'd127;
    frame_cand[3] = 8'd128;
    send_frame(4);
    wait_drained();

    // side 1 clamps to 2, top threshold, raw reference values near the codes
    cfg_write(CFG_IMAGE_SIDE, {7'h7f, 8'd1});
    cfg_write(CFG_MIN_MATCHES, 15'd16384);
    frame_ref[0]  = BgCode; frame_ref[1]  = BgCode; frame_ref[2]  = 8'd1;
    frame_ref[3]  = 8'd254;
    frame_cand[0] = 8'd255; frame_cand[1] = 8'd128; frame_cand[2] = 8'd0;
    frame_cand[3] = 8'd127;
    send_frame(4);
    wait_drained();

    cfg_write(CFG_IMAGE_SIDE, 15'd3);
    cfg_write(CFG_MIN_MATCHES, 15'd5);
    build_frame(3, FRAME_ORIENTED, 0);
    send_frame(9);

    // side cut during a load: next beat completes the frame
    build_frame(3, FRAME_BINARY, 0);
    send_frame(6);
    wait_drained();
    cfg_write(CFG_IMAGE_SIDE, 15'd2);
    send_pixel(frame_ref[6], frame_cand[6]);
    wait_drained();

    rand_start = pixel_count;
    group = 0;
    while (pixel_count < rand_start + 900 || group < 5) begin
      wait_drained();
      k = $urandom_range(99);
      if (group == 4) sidev = 3;
      else if (k < 70) sidev = $urandom_range(6, 2);
      else if (k < 85) sidev = $urandom_range(12, 7);
      else if (k < 92) sidev = $urandom_range(1);
      else sidev = $urandom_range(20, 13);
      d = {7'($urandom), 8'(sidev)};
      cfg_write(CFG_IMAGE_SIDE, d);
      n = sb.frame_side();
      k = $urandom_range(9);
      if (k == 0) d = 15'($urandom_range(16384));
      else if (k == 1) d = '0;
      else d = 15'($urandom_range(n * n + 1));
      cfg_write(CFG_MIN_MATCHES, d);

      if (group % 4 == 3 && n >= 3) begin
        build_frame(n, FRAME_BINARY, 0);
        k = $urandom_range(n * n - 1, 1);
        send_frame(k);
        wait_drained();
        cfg_write(CFG_IMAGE_SIDE, 15'($urandom_range(n - 1, 2)));
        send_pixel(frame_ref[k], frame_cand[k]);
        while (sb.loading()) send_pixel(8'($urandom_range(255)), 8'($urandom_range(255)));
        n = sb.frame_side();
      end

      // long receiver hold-off while frames keep coming
      if (group == 4) hold_left = 600;

      for (int f = 0; f < 5; f++) begin
        rel = pixel_count - rand_start;
        if (rel < 300) begin
          tx_idle = 28;
          rx_idle = 62;
        end else if (rel < 600) begin
          tx_idle = 62;
          rx_idle = 28;
        end else begin
          tx_idle = 0;
          rx_idle = 0;
        end
        k = $urandom_range(99);
        if (k < 20) kind = FRAME_RAW;
        else if (k < 45) kind = FRAME_BINARY;
        else kind = FRAME_ORIENTED;
        build_frame(n, kind, $urandom_range(25));
        send_frame(n * n);
      end
      group++;
    end

    // top side through clamping keeps loading; a cut to 4 ends an exact match
    wait_drained();
    tx_idle = 0;
    rx_idle = 0;
    cfg_write(CFG_IMAGE_SIDE, {7'h00, 8'hff});
    cfg_write(CFG_MIN_MATCHES, 15'd16);
    build_frame(4, FRAME_ORIENTED, 0);
    send_frame(12);
    wait_drained();
    cfg_write(CFG_IMAGE_SIDE, 15'd4);
    for (int unsigned i = 12; i < 16; i++) send_pixel(frame_ref[i], frame_cand[i]);
    wait_drained();
    repeat (20) @(posedge clk);

    if (sb.errors == 0) begin
      $display("binary_shape_match_dihedral_core test passed");
    end else begin
      $display("binary_shape_match_dihedral_core test failed");
    end
    $finish;
  end

  initial begin
    #40000000;
    $display("binary_shape_match_dihedral_core test failed");
    $finish;
  end

endmodule
`default_nettype wire

[filelist.f]
rtl/bsmd_pkg.sv
rtl/bsmd_seq.sv
rtl/bsmd_scan.sv
rtl/binary_shape_match_dihedral_core.sv
verif/binary_shape_match_dihedral_core_tb.sv
